@@ hw/rtl/bsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Bucket scatter distributor package
// Widths, fixed configuration and shared types of the distributor.
// ----------------------------------------------------------------------------
package bsd_pkg;

  localparam int DATA_W    = 32;
  localparam int DEST_W    = 12;
  localparam int BUCKET_W  = 6;
  localparam int SLOT_W    = 2;
  localparam int CNT_W     = 3;
  localparam int NUM_BUCKETS = 1 << BUCKET_W;

  // Row length and bucket capacity of this build.
  localparam int ROW_LEN    = 64;
  localparam int BUCKET_CAP = 4;

  // The counter width caps the usable capacity; a capacity below one acts as one.
  localparam int COUNT_MAX = (1 << CNT_W) - 1;
  localparam int CAP_EFF   = (BUCKET_CAP < 1) ? 1 :
                             ((BUCKET_CAP > COUNT_MAX) ? COUNT_MAX : BUCKET_CAP);

  typedef logic [BUCKET_W-1:0] bucket_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [CNT_W-1:0]    count_t;
  typedef logic [DEST_W-1:0]   dest_t;
  typedef logic signed [DATA_W-1:0] data_t;

  // Write-back request from the placement stage to the counter memory.
  typedef struct packed {
    logic    wr_en;
    bucket_t wr_addr;
    count_t  wr_data;
    logic    clr_all;
  } cnt_wr_t;

endpackage

@@ hw/rtl/bucket_scatter_distributor.sv @@
// ----------------------------------------------------------------------------
// Bucket scatter distributor
// Assigns each incoming request a bucket and a slot from per-bucket counters.
// ----------------------------------------------------------------------------
// Usage:
// Each input request carries data_word, dest_index and row_end. The bucket is
// dest_index divided by the row length; its fill counter gives the slot. A
// full bucket drops the request: overflow is set, slot_id is zero and the
// counter stays. A request with row_end set clears every counter after it is
// placed. Exactly one result leaves on the output channel for each request,
// carrying bucket_id, slot_id, the data and the destination.
// A result passes through the placement stage and then the output register.
// The block takes one request per cycle while results are drained; this rate
// is set by the single read/write port pair of the counter memory, read when
// a request is accepted and written back as it leaves the placement stage,
// with the updated count forwarded when the next request hits the same bucket.
// Reset clears all counters in the same cycle (per-bucket valid bits) and
// empties the pipeline. When the receiver stalls, the result waits in the
// output register, one more request waits in the placement stage, and
// in_ready then drops until the output is taken.
// ----------------------------------------------------------------------------
module bucket_scatter_distributor (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bsd_pkg::data_t   data_word,
  input  bsd_pkg::dest_t   dest_index,
  input  logic             row_end,
  output logic             out_valid,
  input  logic             out_ready,
  output bsd_pkg::bucket_t bucket_id,
  output bsd_pkg::slot_t   slot_id,
  output bsd_pkg::data_t   out_data,
  output bsd_pkg::dest_t   out_dest,
  output logic             overflow
);
  import bsd_pkg::*;

  // Placement stage registers.
  logic    s1_valid;
  data_t   s1_data;
  dest_t   s1_dest;
  logic    s1_row_end;
  bucket_t s1_bucket;
  logic    fwd_hit;
  count_t  fwd_cnt;

  logic    accept;
  logic    s1_advance;
  bucket_t in_bucket;
  count_t  rd_cnt;
  count_t  cnt_cur;
  count_t  cnt_new;
  logic    ovf;
  cnt_wr_t wr;

  // Row length is a power of two in this build, so this is a plain shift.
  assign in_bucket = BUCKET_W'(dest_index / ROW_LEN);

  // The placement stage moves on whenever the output register is free or
  // being emptied; a new request enters whenever the stage is free or moving.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;

  bsd_count_mem u_count_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_bucket),
    .rd_data (rd_cnt),
    .wr      (wr)
  );

  // The memory read for a request happens in the same cycle as the write of
  // the request ahead of it, so that write (or its row clear) is forwarded.
  assign cnt_cur = fwd_hit ? fwd_cnt : rd_cnt;
  assign ovf     = (cnt_cur >= CNT_W'(CAP_EFF));
  assign cnt_new = cnt_cur + CNT_W'(1);

  always_comb begin
    wr.wr_en   = s1_advance && !ovf;
    wr.wr_addr = s1_bucket;
    wr.wr_data = cnt_new;
    wr.clr_all = s1_advance && s1_row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data    <= data_word;
      s1_dest    <= dest_index;
      s1_row_end <= row_end;
      s1_bucket  <= in_bucket;
      fwd_hit    <= s1_advance && (s1_row_end || (s1_bucket == in_bucket));
      if (s1_row_end) begin
        fwd_cnt <= '0;
      end else if (ovf) begin
        fwd_cnt <= cnt_cur;
      end else begin
        fwd_cnt <= cnt_new;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      bucket_id <= s1_bucket;
      slot_id   <= ovf ? '0 : cnt_cur[SLOT_W-1:0];
      out_data  <= s1_data;
      out_dest  <= s1_dest;
      overflow  <= ovf;
    end
  end

endmodule

@@ hw/rtl/bsd_count_mem.sv @@
// ----------------------------------------------------------------------------
// Bucket fill counter memory
// One read and one write port, registered read data, and a valid bit per
// bucket so that reset and row ends clear all counters together.
// ----------------------------------------------------------------------------
module bsd_count_mem (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  bsd_pkg::bucket_t rd_addr,
  output bsd_pkg::count_t  rd_data,
  input  bsd_pkg::cnt_wr_t wr
);
  import bsd_pkg::*;

  count_t                 mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] vld;

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[wr.wr_addr] <= wr.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || wr.clr_all) begin
      vld <= '0;
    end else if (wr.wr_en) begin
      vld[wr.wr_addr] <= 1'b1;
    end
  end

  // An entry not written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

@@ test/bucket_scatter_distributor_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bucket scatter distributor testbench
// Streams requests through the distributor under several handshake pressure
// phases, predicts each placement from a local copy of the bucket counters,
// and checks every result field in order of acceptance.
// ----------------------------------------------------------------------------
module bucket_scatter_distributor_test;

  import bsd_pkg::*;

  // Effective row length and capacity as the counters see them.
  localparam int ROW_SPAN   = (ROW_LEN < 1) ? 1 : ROW_LEN;
  localparam int FILL_LIMIT = (BUCKET_CAP < 1) ? 1 :
                              ((BUCKET_CAP > 7) ? 7 : BUCKET_CAP);
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    data_t data;
    dest_t dest;
    logic  last;
  } request_t;

  typedef struct {
    bucket_t bucket;
    slot_t   slot;
    data_t   data;
    dest_t   dest;
    logic    dropped;
  } placement_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_ready;
  data_t   data_word = '0;
  dest_t   dest_index = '0;
  logic    row_end = 1'b0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  bucket_t bucket_id;
  slot_t   slot_id;
  data_t   out_data;
  dest_t   out_dest;
  logic    overflow;

  // Requests not yet presented, and placements expected but not yet seen.
  request_t   requests_waiting[$];
  placement_t placements_due[$];

  // Local copy of the per-bucket fill counters.
  count_t bucket_fill [NUM_BUCKETS];

  int sender_idle_pct = 0;
  int stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  request_t upcoming;

  bucket_scatter_distributor uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_word (data_word),
    .dest_index(dest_index),
    .row_end   (row_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bucket_id (bucket_id),
    .slot_id   (slot_id),
    .out_data  (out_data),
    .out_dest  (out_dest),
    .overflow  (overflow)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Works out where an accepted request lands and advances the counters.
  function automatic placement_t place_request(request_t r);
    placement_t p;
    int quotient;
    int held;
    quotient = int'(r.dest) / ROW_SPAN;
    p.bucket = bucket_t'(quotient);
    p.data = r.data;
    p.dest = r.dest;
    held = int'(bucket_fill[p.bucket]);
    if (held >= FILL_LIMIT) begin
      p.dropped = 1'b1;
      p.slot = '0;
    end else begin
      p.dropped = 1'b0;
      p.slot = slot_t'(held);
      bucket_fill[p.bucket] = count_t'(held + 1);
    end
    // A row end clears every counter after its own request, dropped or not.
    if (r.last) begin
      foreach (bucket_fill[i]) bucket_fill[i] = '0;
    end
    return p;
  endfunction

  function automatic void add_request(data_t d, dest_t x, logic last);
    request_t r;
    r.data = d;
    r.dest = x;
    r.last = last;
    requests_waiting.push_back(r);
  endfunction

  function automatic dest_t dest_in_bucket(int b);
    return dest_t'(b * ROW_SPAN + $urandom_range(0, ROW_SPAN - 1));
  endfunction

  // Mostly well-formed rows that hammer two hot buckets so that they fill up
  // and overflow, with some fully random requests mixed in as noise.
  task automatic queue_random_rows(int count);
    int queued;
    int row_length;
    int hot_a;
    int hot_b;
    int b;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(0, 9) == 0) begin
        add_request(data_t'($urandom), dest_t'($urandom), logic'($urandom_range(0, 1)));
        queued++;
      end else begin
        row_length = $urandom_range(1, 20);
        hot_a = $urandom_range(0, NUM_BUCKETS - 1);
        hot_b = $urandom_range(0, NUM_BUCKETS - 1);
        for (int i = 0; i < row_length; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            b = $urandom_range(0, NUM_BUCKETS - 1);
          end else begin
            b = $urandom_range(0, 1) ? hot_a : hot_b;
          end
          add_request(data_t'($urandom), dest_in_bucket(b), logic'(i == row_length - 1));
        end
        queued += row_length;
      end
    end
  endtask

  function automatic void check_field(string name, longint expected, longint actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      mismatch_count++;
    end
  endfunction

  // Driver: presents the next waiting request, holding it until accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        placements_due.push_back(place_request(request_t'{data_word, dest_index, row_end}));
      end
      if (!in_valid || in_ready) begin
        if (requests_waiting.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          upcoming = requests_waiting.pop_front();
          in_valid <= 1'b1;
          data_word <= upcoming.data;
          dest_index <= upcoming.dest;
          row_end <= upcoming.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expected placement.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (placements_due.size() == 0) begin
          $error("unexpected result: bucket_id %0d, out_dest %0d", bucket_id, out_dest);
          mismatch_count++;
        end else begin
          check_field("bucket_id", longint'(placements_due[0].bucket), longint'(bucket_id));
          check_field("slot_id", longint'(placements_due[0].slot), longint'(slot_id));
          check_field("out_data", longint'(placements_due[0].data), longint'(out_data));
          check_field("out_dest", longint'(placements_due[0].dest), longint'(out_dest));
          check_field("overflow", longint'(placements_due[0].dropped), longint'(overflow));
          void'(placements_due.pop_front());
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic drain_all;
    while (requests_waiting.size() != 0 || in_valid) @(negedge clk);
    while (placements_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    foreach (bucket_fill[i]) bucket_fill[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: field extremes and bucket boundaries.
    add_request(32'sh7fffffff, 12'd0, 1'b0);
    add_request(32'sh80000000, 12'd4095, 1'b0);
    add_request(-32'sd1, dest_t'(ROW_SPAN - 1), 1'b0);
    add_request(32'sd0, dest_t'(ROW_SPAN), 1'b0);
    // Fill one bucket past capacity; the row end lands on a dropped request.
    for (int i = 0; i < FILL_LIMIT + 2; i++) begin
      add_request(data_t'($urandom), dest_in_bucket(5), logic'(i == FILL_LIMIT + 1));
    end
    // After the clear the same bucket starts again at slot zero.
    add_request(32'sh55555555, dest_in_bucket(5), 1'b0);
    add_request(32'shaaaaaaaa, dest_in_bucket(5), 1'b0);
    // Row end on a placed request, then the top bucket from empty.
    add_request(32'sh0000ffff, 12'd4095, 1'b1);
    add_request(32'shffff0000, 12'd4032, 1'b0);
    add_request(32'sh12345678, 12'd4064, 1'b0);
    add_request(32'sh87654321, 12'd2730, 1'b0);
    add_request(32'sh0f0f0f0f, 12'd1365, 1'b1);

    // Phase one: no idling at either side.
    queue_random_rows(480);
    drain_all();

    // The sender idles most of the time while the receiver never stalls.
    sender_idle_pct = 87;
    stall_pct = 0;
    queue_random_rows(480);
    drain_all();

    sender_idle_pct = 0;
    stall_pct = 87;
    queue_random_rows(480);
    drain_all();

    sender_idle_pct = 25;
    stall_pct = 25;
    queue_random_rows(480);
    drain_all();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && placements_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
